>>> hdl/ccbc_pkg.sv
// ----------------------------------------------------------------------------
// ccbc_pkg : shared definitions for the convolutional byte codec
// Holds the mode codes, the trellis tables and the derived message widths.
// ----------------------------------------------------------------------------
package ccbc_pkg;

    // Number of message bits taken through the trellis for each item.
    localparam int MESSAGE_BITS = 8;

    // Widths of the fixed payload fields.
    localparam int DATA_W   = 8;
    localparam int CODE_W   = 32;
    localparam int SYM_W    = 4;
    localparam int STATE_W  = 3;
    localparam int N_STATES = 1 << STATE_W;

    // Working widths: wide enough for the message and for every field.
    localparam int MSG_W  = (MESSAGE_BITS > DATA_W) ? MESSAGE_BITS : DATA_W;
    localparam int WORD_W = (SYM_W * MESSAGE_BITS > CODE_W) ? SYM_W * MESSAGE_BITS : CODE_W;

    typedef logic [STATE_W-1:0] state_t;
    typedef logic [SYM_W-1:0]   sym_t;

    // Operation codes carried in the mode field.
    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    // Expected branch symbols and successor states, indexed by state.
    localparam sym_t SYM_ONE [N_STATES] = '{
        4'd14, 4'd11, 4'd9, 4'd12, 4'd11, 4'd14, 4'd12, 4'd9
    };
    localparam sym_t SYM_ZERO [N_STATES] = '{
        4'd0, 4'd5, 4'd7, 4'd2, 4'd5, 4'd0, 4'd2, 4'd7
    };
    localparam state_t NXT_ONE [N_STATES] = '{
        3'd4, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6, 3'd7, 3'd7
    };
    localparam state_t NXT_ZERO [N_STATES] = '{
        3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3
    };

endpackage

>>> hdl/ccbc_if.sv
// ----------------------------------------------------------------------------
// ccbc_if : valid/ready channels of the convolutional byte codec
// Request channel (mode and operands) and response channel (results).
// ----------------------------------------------------------------------------
interface ccbc_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [7:0]  data_byte;
    logic [31:0] code_word;

    modport source (output valid, output mode, output data_byte, output code_word,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input code_word,
                    output ready);
endinterface

interface ccbc_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] encoded_word;
    logic [7:0]  decoded_byte;

    modport source (output valid, output encoded_word, output decoded_byte,
                    input ready);
    modport sink   (input valid, input encoded_word, input decoded_byte,
                    output ready);
endinterface

>>> hdl/ccbc_encoder.sv
// ----------------------------------------------------------------------------
// ccbc_encoder : rate-1/4 convolutional encoder for one message
// Walks the three-bit shift register from zero and packs the symbols.
// ----------------------------------------------------------------------------
module ccbc_encoder
    import ccbc_pkg::*;
(
    input  logic [DATA_W-1:0] data_byte,
    output logic [CODE_W-1:0] encoded_word
);

    always_comb
    begin
        logic [MSG_W-1:0]  msg;
        logic [WORD_W-1:0] word;
        state_t            st;
        logic              b;
        logic              par;

        msg  = MSG_W'(data_byte);
        word = '0;
        st   = '0;
        for (int i = MESSAGE_BITS - 1; i >= 0; i--)
        begin
            b   = msg[i];
            par = ^st;
            word[SYM_W*i +: SYM_W] = {b, b ^ par, b ^ st[1], par};
            st  = {b, st[STATE_W-1:1]};
        end
        encoded_word = word[CODE_W-1:0];
    end

endmodule

>>> hdl/ccbc_decoder.sv
// ----------------------------------------------------------------------------
// ccbc_decoder : hard-decision trellis walk for one code word
// Takes at most one branch per symbol; an unmatched symbol keeps the state.
// ----------------------------------------------------------------------------
module ccbc_decoder
    import ccbc_pkg::*;
(
    input  logic [CODE_W-1:0] code_word,
    output logic [DATA_W-1:0] decoded_byte
);

    always_comb
    begin
        logic [WORD_W-1:0] code;
        logic [MSG_W-1:0]  msg;
        state_t            st;
        sym_t              sym;

        code = WORD_W'(code_word);
        msg  = '0;
        st   = '0;
        for (int i = MESSAGE_BITS - 1; i >= 0; i--)
        begin
            sym = code[SYM_W*i +: SYM_W];
            if (sym == SYM_ONE[st])
            begin
                msg[i] = 1'b1;
                st     = NXT_ONE[st];
            end
            else if (sym == SYM_ZERO[st])
            begin
                st = NXT_ZERO[st];
            end
        end
        decoded_byte = msg[DATA_W-1:0];
    end

endmodule

>>> hdl/conv_code_byte_codec.sv
// ----------------------------------------------------------------------------
// conv_code_byte_codec : rate-1/4 convolutional byte encoder and decoder
// Each request item is encoded or decoded on its own and gives one response.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload                             | Handshake
//  --------+-----------+-------------------------------------+-------------
//  req     | in        | mode, data_byte[7:0], code_word[31:0] | valid/ready
//  rsp     | out       | encoded_word[31:0], decoded_byte[7:0] | valid/ready
//
// The response is shown from the output register after the request item has
// passed through the input register, and one item is accepted in every
// cycle when the response side keeps up.
// The request is captured in an input register; the encoder or the decoder
// then works on it combinationally and the result lands in the output
// register. The eight-step trellis walk of the decoder sets the logic depth.
// A stalled response holds both registers in turn; req.ready falls only when
// both are full. Reset clears the valid flags only.
//
module conv_code_byte_codec
    import ccbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ccbc_req_if.sink    req,
    ccbc_rsp_if.source  rsp
);

    // Input register stage.
    logic              s1_valid_reg;
    logic              s1_mode_reg;
    logic [DATA_W-1:0] s1_data_reg;
    logic [CODE_W-1:0] s1_code_reg;

    // Output register stage.
    logic              out_valid_reg;
    logic [CODE_W-1:0] encoded_word_reg;
    logic [DATA_W-1:0] decoded_byte_reg;

    logic              s1_adv;
    logic              req_acc;
    logic [CODE_W-1:0] enc_word;
    logic [DATA_W-1:0] dec_byte;
    logic [CODE_W-1:0] encoded_word_next;
    logic [DATA_W-1:0] decoded_byte_next;

    // The output register can take a new result when it is empty or being
    // emptied; the input register can take a request when it is empty or its item moves on.
    assign s1_adv    = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || s1_adv;
    assign req_acc   = req.valid && req.ready;

    ccbc_encoder u_encoder
    (
        .data_byte    (s1_data_reg),
        .encoded_word (enc_word)
    );

    ccbc_decoder u_decoder
    (
        .code_word    (s1_code_reg),
        .decoded_byte (dec_byte)
    );

    // The field that does not belong to the operation reads as zero.
    always_comb
    begin
        if (s1_mode_reg == MODE_DECODE)
        begin
            encoded_word_next = '0;
            decoded_byte_next = dec_byte;
        end
        else
        begin
            encoded_word_next = enc_word;
            decoded_byte_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            s1_mode_reg <= req.mode;
            s1_data_reg <= req.data_byte;
            s1_code_reg <= req.code_word;
        end
        if (s1_adv && s1_valid_reg)
        begin
            encoded_word_reg <= encoded_word_next;
            decoded_byte_reg <= decoded_byte_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.encoded_word = encoded_word_reg;
    assign rsp.decoded_byte = decoded_byte_reg;

    // An accepted request is always held in the input stage next cycle.
    a_req_captured: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> s1_valid_reg)
        else $error("accepted request not captured in input stage");

    // An item in the input stage that cannot move stays, with its mode.
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_mode_reg)))
        else $error("input stage item lost while output stalled");

    // An item leaving the input stage always arrives in the output register.
    a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_adv) |=> out_valid_reg)
        else $error("item dropped between stages");

    // Only one of the two result fields can carry data.
    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (encoded_word_reg == '0 || decoded_byte_reg == '0))
        else $error("both result fields non-zero");

endmodule
